// ===== rtl/pmot_pkg.sv =====
// Shared types and constants for the pitch median octave tracker.
`default_nettype none
package pmot_pkg;

  localparam int PITCH_W    = 24;
  localparam int RATIO_W    = 18;
  localparam int RATIO_FRAC = 16;
  localparam int PROD_W     = PITCH_W + RATIO_W;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd69433;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // One request as classified by the front end.
  typedef struct packed {
    logic               nonzero;
    logic [PITCH_W-1:0] est;
  } req_t;

endpackage
`default_nettype wire

// ===== rtl/pitch_median_octave_tracker_unit.sv =====
// Top level of the pitch median octave tracker.
// One held pitch comes out for every estimate taken in. An empty (zero)
// estimate passes straight through the back end to the output register; a
// nonzero one goes through the rank search, which visits one ring entry per
// cycle, then the octave fix, the band multiply and the decision. A four-entry
// queue in front lets estimates be taken every cycle, until it fills, while the
// back end works, and one output register lets the back end work on the next
// estimate while the last result waits. The user must write the ratio register
// only while the block is idle; the block itself does not enforce it.
`default_nettype none
module pitch_median_octave_tracker_unit #(
  parameter int WINDOW_LEN = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pmot_pkg::RATIO_W-1:0]  cfg_wr_data,   // ratio, Q2.16
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [pmot_pkg::PITCH_W-1:0]  s_axis_tdata,  // [23:0] pitch_estimate
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [pmot_pkg::PITCH_W-1:0]       m_axis_tdata   // [23:0] held_pitch
);
  import pmot_pkg::*;

  logic               ratio;
  logic [RATIO_W-1:0] ratio_q;
  logic               req_valid;
  logic               req_ready;
  req_t               req;

  assign ratio = cfg_wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_q <= RATIO_RESET;
    end else if (ratio) begin
      ratio_q <= cfg_wr_data;
    end
  end

  pmot_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  pmot_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ratio     (ratio_q),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== rtl/pmot_front.sv =====
// Front end: accepts pitch estimates, marks the empty ones and queues them.
`default_nettype none
module pmot_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [pmot_pkg::PITCH_W-1:0] in_data,
  output logic                        req_valid,
  input  wire logic                   req_ready,
  output pmot_pkg::req_t              req
);
  import pmot_pkg::*;

  req_t                queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] head;
  logic [QUEUE_AW-1:0] tail;
  logic [QUEUE_CW-1:0] count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign req_valid = (count != '0);
  assign req       = queue[head];
  assign push      = in_valid && in_ready;
  assign pop       = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[tail].nonzero <= |in_data;
      queue[tail].est     <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop) head <= head + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pmot_back.sv =====
// Back end: ring of estimates, rank-search median, octave fix and band hold.
`default_nettype none
module pmot_back #(
  parameter int WINDOW_LEN = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [pmot_pkg::RATIO_W-1:0]  ratio,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire pmot_pkg::req_t                req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pmot_pkg::PITCH_W-1:0]       out_data
);
  import pmot_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam logic [IDX_W-1:0] MID  = IDX_W'(WINDOW_LEN / 2);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_LEN - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RANK = 3'd1;
  localparam logic [2:0] S_CORR = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [PITCH_W-1:0] window [WINDOW_LEN];
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   rank;
  logic [2:0]         state;
  logic [PITCH_W-1:0] held;
  logic [PITCH_W-1:0] med;
  logic [PITCH_W-1:0] mcorr;
  logic [PITCH_W-1:0] mcorr_next;
  logic [PITCH_W-1:0] half_fix;
  logic [PROD_W-1:0]  prod_hr;
  logic [PROD_W-1:0]  prod_mr;
  logic               above;
  logic               below;
  logic               replace;
  logic               can_push;
  logic               out_push;

  assign can_push  = !out_valid || out_ready;
  assign req_ready = (state == S_IDLE) && (req.nonzero || can_push);
  assign out_push  = ((state == S_IDLE) && req_valid && req_ready && !req.nonzero) ||
                     ((state == S_DONE) && can_push);

  // Rank of the candidate: entries below it, ties broken by position.
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if ((window[j] < window[idx]) ||
          ((window[j] == window[idx]) && (IDX_W'(j) < idx))) begin
        rank = rank + 1'b1;
      end
    end
  end

  // Halve a median at twice the held pitch, then double one at half of it.
  always_comb begin
    half_fix = ({1'b0, med} == {held, 1'b0}) ? (med >> 1) : med;
    if ({half_fix, 1'b0} == {1'b0, held}) begin
      mcorr_next = {half_fix[PITCH_W-2:0], 1'b0};
    end else begin
      mcorr_next = half_fix;
    end
  end

  assign above   = PROD_W'({mcorr, {RATIO_FRAC{1'b0}}}) > prod_hr;
  assign below   = prod_mr < PROD_W'({held, {RATIO_FRAC{1'b0}}});
  assign replace = above || below || (held == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) window[k] <= '0;
    end else if ((state == S_IDLE) && req_valid && req_ready && req.nonzero) begin
      window[slot] <= req.est;
    end
    if ((state == S_RANK) && (rank == MID)) med <= window[idx];
    if (state == S_CORR) mcorr <= mcorr_next;
    if (state == S_MUL) begin
      prod_hr <= PROD_W'(held) * PROD_W'(ratio);
      prod_mr <= PROD_W'(mcorr) * PROD_W'(ratio);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      idx       <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            if (req.nonzero) begin
              slot  <= (slot == LAST) ? '0 : slot + 1'b1;
              idx   <= '0;
              state <= S_RANK;
            end else begin
              out_data <= held;
            end
          end
        end
        S_RANK: begin
          idx <= idx + 1'b1;
          if (idx == LAST) state <= S_CORR;
        end
        S_CORR: state <= S_MUL;
        S_MUL:  state <= S_DONE;
        S_DONE: begin
          // hold here until the output register is free
          if (can_push) begin
            if (replace) held <= mcorr;
            out_data <= replace ? mcorr : held;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pmot_checker.sv =====
// Port-level checks for the pitch median octave tracker, bound to the top level.
`default_nettype none
module pmot_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending;
  logic       seen_pitch;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      seen_pitch <= 1'b0;
    end else begin
      pending <= pending + {3'b0, in_acc} - {3'b0, out_acc};
      if (in_acc && (s_axis_tdata != 24'd0)) seen_pitch <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (pending != 4'd0))
    else $error("result delivered without a pending request");

  a_zero_first: assert property (@(posedge clk) disable iff (rst)
    out_acc && !seen_pitch |-> (m_axis_tdata == 24'd0))
    else $error("nonzero held pitch before any pitch was seen");

endmodule

bind pitch_median_octave_tracker_unit pmot_checker u_pmot_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== verif/tb_pitch_median_octave_tracker_unit.sv =====
// Self-checking testbench for the pitch median octave tracker: stream stimulus, tracking predictor, result checks.
`default_nettype none
module tb_pitch_median_octave_tracker_unit;

  localparam int WINDOW_LEN   = 7;
  localparam int PITCH_W      = pmot_pkg::PITCH_W;
  localparam int RATIO_W      = pmot_pkg::RATIO_W;
  localparam longint RATIO_ONE = 64'd1 << pmot_pkg::RATIO_FRAC;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_OFF_LEN = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [RATIO_W-1:0]   cfg_wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PITCH_W-1:0]   s_axis_tdata = '0;   // [23:0] pitch_estimate
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PITCH_W-1:0]   m_axis_tdata;        // [23:0] held_pitch

  pitch_median_octave_tracker_unit #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker state as the predictor sees it
  logic [PITCH_W-1:0] pitch_ring [WINDOW_LEN];
  int unsigned        ring_slot;
  logic [PITCH_W-1:0] held_pitch_model;
  logic [RATIO_W-1:0] band_ratio;

  logic [PITCH_W-1:0] held_pitch_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_req;
  int unsigned hold_off_left;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned estimates_sent;
  int unsigned zero_estimates;
  int unsigned ratio_settings;
  int unsigned cycle_count;

  logic [PITCH_W-1:0] tone_pitch;

  initial begin
    for (int i = 0; i < WINDOW_LEN; i++) pitch_ring[i] = '0;
    ring_slot        = 0;
    held_pitch_model = '0;
    band_ratio       = pmot_pkg::RATIO_RESET;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_req     = 0;
    hold_off_left    = 0;
    mismatch_count   = 0;
    results_checked  = 0;
    estimates_sent   = 0;
    zero_estimates   = 0;
    ratio_settings   = 1;
    cycle_count      = 0;
    tone_pitch       = 24'd220 << 8;
  end

  // Median of the ring, octave correction, then the hysteresis band decision
  function automatic logic [PITCH_W-1:0] track_pitch(input logic [PITCH_W-1:0] est);
    logic [PITCH_W-1:0] sorted [WINDOW_LEN];
    logic [PITCH_W-1:0] v;
    logic [63:0]        med;
    logic [63:0]        held;
    logic               above;
    logic               below;
    int                 i;
    int                 j;
    if (est != '0) begin
      if (ring_slot >= WINDOW_LEN) ring_slot = 0;
      pitch_ring[ring_slot] = est;
      sorted = pitch_ring;
      for (i = 1; i < WINDOW_LEN; i++) begin
        v = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      med  = 64'(sorted[WINDOW_LEN/2]);
      held = 64'(held_pitch_model);
      if (med == 2 * held) med = med / 2;
      if (2 * med == held) med = med * 2;
      above = (med * RATIO_ONE) > (held * 64'(band_ratio));
      below = (med * 64'(band_ratio)) < (held * RATIO_ONE);
      if (above || below || held == 0) held_pitch_model = med[PITCH_W-1:0];
      ring_slot = (ring_slot + 1) % WINDOW_LEN;
    end
    return held_pitch_model;
  endfunction

  // Start and end at a falling edge; leave tvalid high for a following request
  task automatic offer_estimate(input logic [PITCH_W-1:0] est);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= est;
    do @(posedge clk); while (!s_axis_tready);
    held_pitch_due.push_back(track_pitch(est));
    estimates_sent++;
    if (est == '0) zero_estimates++;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (held_pitch_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    band_ratio = value;
    ratio_settings++;
  endtask

  // Mostly a voiced tone with jitter, plus octave jumps, repeats, silence and noise
  function automatic logic [PITCH_W-1:0] pick_estimate();
    int unsigned        pick;
    int unsigned        shift;
    logic [PITCH_W-1:0] jitter;
    pick = $urandom_range(99);
    if ($urandom_range(31) == 0) tone_pitch = PITCH_W'($urandom_range(50 << 8, 1200 << 8));
    if (pick < 8) return '0;
    if (pick < 20) return PITCH_W'($urandom());
    if (pick < 35) begin
      if (held_pitch_model == '0) return tone_pitch;
      return $urandom_range(1) ? PITCH_W'(held_pitch_model << 1) : (held_pitch_model >> 1);
    end
    if (pick < 45) return held_pitch_model == '0 ? tone_pitch : held_pitch_model;
    shift  = $urandom_range(3, 7);
    jitter = PITCH_W'($urandom_range(tone_pitch >> shift));
    return $urandom_range(1) ? tone_pitch + jitter : tone_pitch - jitter;
  endfunction

  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      hold_off_left = hold_off_req;
      hold_off_req  = 0;
    end
    if (hold_off_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (held_pitch_due.size() == 0) begin
        $error("held_pitch: unexpected result %0d with nothing outstanding", m_axis_tdata);
        mismatch_count++;
      end else begin
        if (m_axis_tdata !== held_pitch_due[0]) begin
          $error("held_pitch mismatch: expected %0d, actual %0d",
                 held_pitch_due[0], m_axis_tdata);
          mismatch_count++;
        end
        void'(held_pitch_due.pop_front());
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Silence, reset zeros in the median, octave halving and doubling, field extremes
  task automatic test_directed_tracking();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    offer_estimate('0);
    repeat (3) offer_estimate(24'd100 << 8);
    offer_estimate(24'd100 << 8);
    offer_estimate('0);
    repeat (4) offer_estimate(24'd200 << 8);
    repeat (4) offer_estimate(24'd50 << 8);
    repeat (4) offer_estimate(24'hFFFFFF);
    repeat (4) offer_estimate(24'd1);
    offer_estimate(24'h800000);
  endtask

  task automatic test_random_tracking(input logic [RATIO_W-1:0] ratio,
                                      input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned count);
    write_ratio(ratio);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) offer_estimate(pick_estimate());
  endtask

  // Hold the output long enough for the input queue to fill and stall the sender
  task automatic test_output_hold_off();
    write_ratio(RATIO_W'(65537));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_off_req = HOLD_OFF_LEN;
    @(negedge clk);
    repeat (150) offer_estimate(pick_estimate());
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_tracking();
    test_random_tracking(pmot_pkg::RATIO_RESET, 0, 0, 250);
    test_random_tracking(RATIO_W'(262143), 79, 0, 200);
    test_random_tracking(RATIO_W'(65536), 0, 79, 200);
    test_random_tracking(RATIO_W'(0), 36, 36, 200);
    test_random_tracking(RATIO_W'(32768), 0, 0, 150);
    test_random_tracking(RATIO_W'($urandom_range(65536, 262143)), 36, 36, 200);
    test_output_hold_off();
    test_random_tracking(pmot_pkg::RATIO_RESET, 79, 79, 200);

    settle_idle();
    $display("Tracked %0d estimates (%0d silent), %0d held pitches checked, %0d ratio settings.",
             estimates_sent, zero_estimates, results_checked, ratio_settings);
    $display("Ratio ran from zero to full scale under mixed idling and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
